### rtl/core/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared widths, register indexes and types of the far object reprojector.
// ----------------------------------------------------------------------------
`default_nettype none

package fsr_pkg;

	localparam int FRAC_BITS = 8;
	localparam int POS_W     = 32;
	localparam int OBJ_W     = 24;
	localparam int MAG_W     = 32;
	localparam int SUM_W     = 2 * MAG_W + 2;
	localparam int LEN_W     = SUM_W / 2;
	localparam int ILEN_W    = LEN_W - FRAC_BITS;
	localparam int SQ_STEPS  = LEN_W;
	localparam int NUM_W     = 63;
	localparam int DIV_STEPS = 39;
	localparam int REM_W     = LEN_W;
	localparam int CFG_W     = 32;

	localparam logic [31:0] SCALE_ONE = 32'h0001_0000;
	localparam logic [31:0] SCALE_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		REG_LIMIT  = 2'd0,
		REG_RADIUS = 2'd1,
		REG_SNUM   = 2'd2,
		REG_SMUL   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic [2:0][POS_W-1:0] cam;
		logic [2:0][OBJ_W-1:0] obj;
	} sq_carry_t;

	typedef struct packed {
		logic                  far;
		logic                  len_zero;
		logic                  ilen_zero;
		logic [LEN_W-1:0]      len;
		logic [ILEN_W-1:0]     ilen;
		logic [2:0]            neg;
		logic [2:0][POS_W-1:0] cam;
		logic [2:0][OBJ_W-1:0] obj;
	} dv_carry_t;

	typedef struct packed {
		logic                  far;
		logic [2:0][POS_W-1:0] place;
		logic [31:0]           scale;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/far_object_sphere_reproject_top.sv
// ----------------------------------------------------------------------------
// far_object_sphere_reproject_top
// Places far objects on a sphere around the camera and scales them down.
// ----------------------------------------------------------------------------
// Takes one item per clock and delivers one result per clock when the output
// side keeps up; an item without geometry gives no result. The pipeline runs
// difference, square and sum; the bit-per-stage square root; the numerator
// products; four bit-per-stage dividers (three offsets and the scale); and
// then offset, saturation and scale product, in that order.
// An output register with a
// one-item skid stage holds results; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module far_object_sphere_reproject_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        has_geometry,
	input  logic signed [31:0] cam_x,
	input  logic signed [31:0] cam_y,
	input  logic signed [31:0] cam_z,
	input  logic signed [23:0] obj_x,
	input  logic signed [23:0] obj_y,
	input  logic signed [23:0] obj_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_far,
	output logic signed [31:0] place_x,
	output logic signed [31:0] place_y,
	output logic signed [31:0] place_z,
	output logic [31:0] uniform_scale
);

	localparam int SQ = fsr_pkg::SQ_STEPS;
	localparam int DV = fsr_pkg::DIV_STEPS;

	// configuration
	logic [23:0] limit_q;
	logic [30:0] radius_q;
	logic [31:0] snum_q;
	logic [31:0] smul_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= 24'd1024;
			radius_q <= 31'd256000;
			snum_q   <= 32'd65536;
			smul_q   <= 32'd65536;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fsr_pkg::REG_LIMIT:  limit_q  <= cfg_data[23:0];
				fsr_pkg::REG_RADIUS: radius_q <= cfg_data[30:0];
				fsr_pkg::REG_SNUM:   snum_q   <= cfg_data;
				fsr_pkg::REG_SMUL:   smul_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// radius * numerator, scaled down by 2^(FRAC_BITS+16)
	logic [62:0] rs_prod;
	logic [38:0] knum_q;
	assign rs_prod = radius_q * snum_q;
	always_ff @(posedge clk) begin
		knum_q <= rs_prod[62:24];
	end

	logic en;
	logic out_v_q, skid_v_q;
	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	logic [2:0][31:0] cam_in;
	logic [2:0][23:0] obj_in;
	assign cam_in = {cam_z, cam_y, cam_x};
	assign obj_in = {obj_z, obj_y, obj_x};

	// s1: difference
	logic                  v_s1;
	logic [2:0][33:0]      d_s1;
	logic [2:0][31:0]      cam_s1;
	logic [2:0][23:0]      obj_s1;
	// s2: magnitude
	logic                  v_s2;
	fsr_pkg::sq_carry_t    c_s2;
	// s3: squares
	logic                  v_s3;
	logic [2:0][63:0]      sq_s3;
	fsr_pkg::sq_carry_t    c_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && has_geometry;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {{2{obj_in[i][23]}}, obj_in[i], {fsr_pkg::FRAC_BITS{1'b0}}}
					- {{2{cam_in[i][31]}}, cam_in[i]};
				c_s2.mag[i] <= d_s1[i][33] ? 32'(34'd0 - d_s1[i]) : d_s1[i][31:0];
				c_s2.neg[i] <= d_s1[i][33];
				sq_s3[i]    <= c_s2.mag[i] * c_s2.mag[i];
			end
			cam_s1    <= cam_in;
			obj_s1    <= obj_in;
			c_s2.cam  <= cam_s1;
			c_s2.obj  <= obj_s1;
			c_s3      <= c_s2;
		end
	end

	// square root, one result bit per stage
	logic                         sq_v_s    [SQ+1];
	fsr_pkg::sq_carry_t           sq_c_s    [SQ+1];
	logic [fsr_pkg::LEN_W-1:0]    sq_root_s [SQ+1];
	logic [35:0]                  sq_rem_s  [SQ];
	logic [fsr_pkg::SUM_W-1:0]    sq_rad_s  [SQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad_s[0]  <= 66'(sq_s3[0]) + 66'(sq_s3[1]) + 66'(sq_s3[2]);
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_c_s[0]    <= c_s3;
		end
	end

	for (genvar k = 0; k < SQ; k++) begin : g_sq
		logic [35:0] r2, t;
		logic        ge;
		assign r2 = {sq_rem_s[k][33:0], sq_rad_s[k][65:64]};
		assign t  = {1'b0, sq_root_s[k], 2'b01};
		assign ge = r2 >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_root_s[k+1] <= {sq_root_s[k][31:0], ge};
				sq_c_s[k+1]    <= sq_c_s[k];
			end
		end

		if (k < SQ - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					sq_rem_s[k+1] <= ge ? r2 - t : r2;
					sq_rad_s[k+1] <= {sq_rad_s[k][63:0], 2'b00};
				end
			end
		end
	end

	// numerators and near/far decision
	logic [fsr_pkg::LEN_W-1:0]  len;
	logic [fsr_pkg::ILEN_W-1:0] ilen;
	logic [2:0][62:0]           pnum;
	assign len  = sq_root_s[SQ];
	assign ilen = len[fsr_pkg::LEN_W-1:fsr_pkg::FRAC_BITS];
	for (genvar i = 0; i < 3; i++) begin : g_pnum
		assign pnum[i] = sq_c_s[SQ].mag[i] * radius_q;
	end

	// four dividers: lanes 0..2 offsets by len, lane 3 scale by ilen
	logic                       dv_v_s   [DV+1];
	fsr_pkg::dv_carry_t         dv_c_s   [DV+1];
	logic [3:0][38:0]           dv_n_s   [DV+1];
	logic [3:0][32:0]           dv_rem_s [DV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= 33'(pnum[i][62:39]);
				dv_n_s[0][i]   <= pnum[i][38:0];
			end
			dv_rem_s[0][3]      <= '0;
			dv_n_s[0][3]        <= knum_q;
			dv_c_s[0].far       <= ilen >= 25'(limit_q);
			dv_c_s[0].len_zero  <= len == '0;
			dv_c_s[0].ilen_zero <= ilen == '0;
			dv_c_s[0].len       <= len;
			dv_c_s[0].ilen      <= ilen;
			dv_c_s[0].neg       <= sq_c_s[SQ].neg;
			dv_c_s[0].cam       <= sq_c_s[SQ].cam;
			dv_c_s[0].obj       <= sq_c_s[SQ].obj;
		end
	end

	for (genvar k = 0; k < DV; k++) begin : g_dv
		logic [3:0][33:0] r2;
		logic [3:0][33:0] dd;
		logic [3:0]       ge;
		for (genvar l = 0; l < 4; l++) begin : g_lane
			if (l == 3) begin : g_k
				assign dd[l] = 34'(dv_c_s[k].ilen);
			end else begin : g_p
				assign dd[l] = 34'(dv_c_s[k].len);
			end
			assign r2[l] = {dv_rem_s[k][l], dv_n_s[k][l][38]};
			assign ge[l] = r2[l] >= dd[l];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 4; l++) begin
					dv_n_s[k+1][l] <= {dv_n_s[k][l][37:0], ge[l]};
				end
				dv_c_s[k+1] <= dv_c_s[k];
			end
		end

		if (k < DV - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					for (int l = 0; l < 4; l++) begin
						dv_rem_s[k+1][l] <= ge[l] ? 33'(r2[l] - dd[l]) : r2[l][32:0];
					end
				end
			end
		end
	end

	// s5: offsets, saturation, scale product
	fsr_pkg::dv_carry_t dc;
	logic [2:0][32:0]   off;
	logic [2:0][32:0]   psum;
	logic [2:0][31:0]   psat;
	assign dc = dv_c_s[DV];
	for (genvar i = 0; i < 3; i++) begin : g_pos
		assign off[i]  = dc.len_zero ? '0 : {2'b00, dv_n_s[DV][i][30:0]};
		assign psum[i] = {dc.cam[i][31], dc.cam[i]} + (dc.neg[i] ? 33'd0 - off[i] : off[i]);
		assign psat[i] = (psum[i][32] != psum[i][31]) ?
			(psum[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : psum[i][31:0];
	end

	logic             v_s5, far_s5, ilen_zero_s5, khi_s5;
	logic [2:0][31:0] pos_s5;
	logic [2:0][23:0] obj_s5;
	logic [63:0]      kp_s5;

	logic                v_s6;
	fsr_pkg::result_t    res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_v_s[DV];
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s5       <= psat;
			obj_s5       <= dc.obj;
			far_s5       <= dc.far;
			ilen_zero_s5 <= dc.ilen_zero;
			khi_s5       <= |dv_n_s[DV][3][38:32];
			kp_s5        <= dv_n_s[DV][3][31:0] * smul_q;

			res_s6.far <= far_s5;
			if (far_s5) begin
				res_s6.place <= pos_s5;
				if (ilen_zero_s5 || (khi_s5 && smul_q != '0) || |kp_s5[63:32]) begin
					res_s6.scale <= fsr_pkg::SCALE_MAX;
				end else begin
					res_s6.scale <= kp_s5[31:0];
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					res_s6.place[i] <= {obj_s5[i], {fsr_pkg::FRAC_BITS{1'b0}}};
				end
				res_s6.scale <= fsr_pkg::SCALE_ONE;
			end
		end
	end

	// output register with skid stage
	fsr_pkg::result_t out_q, skid_q;
	logic emit, load;
	assign emit = en && v_s6;
	assign load = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (load) begin
			out_v_q  <= skid_v_q || emit;
			skid_v_q <= 1'b0;
		end else if (emit) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= skid_v_q ? skid_q : res_s6;
		end else if (emit) begin
			skid_q <= res_s6;
		end
	end

	assign out_valid     = out_v_q;
	assign is_far        = out_q.far;
	assign place_x       = out_q.place[0];
	assign place_y       = out_q.place[1];
	assign place_z       = out_q.place[2];
	assign uniform_scale = out_q.scale;

endmodule

`default_nettype wire

### rtl/core/fsr_chk.sv
// ----------------------------------------------------------------------------
// fsr_chk
// Port-level checks of the far object reprojector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fsr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        is_far,
	input logic signed [31:0] place_x,
	input logic signed [31:0] place_y,
	input logic signed [31:0] place_z,
	input logic [31:0] uniform_scale
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(is_far) && $stable(place_x)
			&& $stable(place_y) && $stable(place_z) && $stable(uniform_scale))
		else $error("stalled result item changed");

	a_near_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_far |-> uniform_scale == fsr_pkg::SCALE_ONE)
		else $error("near item without unit scale");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without output back-pressure");

endmodule

bind far_object_sphere_reproject_top fsr_chk u_fsr_chk (.*);

`default_nettype wire
